// ----- hw/rtl/aes128_pkg.sv -----
package aes128_pkg;

   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int NumRounds  = 10;
   localparam int NumKeys    = NumRounds + 1;

   typedef enum logic [0:0] {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          op;
      logic [63:0]   block_high;
      logic [63:0]   block_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0]   result_high;
      logic [63:0]   result_low;
   } rsp_payload_type;

   // Forward substitution table
   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Inverse substitution table
   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

// ----- hw/rtl/aes128_ram.sv -----
module aes128_ram #(
   parameter int Width = 64,
   parameter int Depth = 22
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/aes128_round.sv -----
module aes128_round (
   input  logic         decrypt,
   input  logic         last,
   input  logic [127:0] state,
   input  logic [127:0] round_key,
   output logic [127:0] result
);

   import aes128_pkg::*;

   logic [7:0] s_b    [16];
   logic [7:0] sh_b   [16];
   logic [7:0] sb_b   [16];
   logic [7:0] ak_b   [16];
   logic [7:0] mx_b   [16];
   logic [7:0] fwd_b  [16];
   logic [7:0] x2, x4, x8;

   // Forward: shift, sub, mix, add. Inverse: shift, sub, add, mix. The last round skips mix.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s_b[i] = state[127-8*i -: 8];
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            sh_b[r+4*c] = decrypt ? s_b[r+4*((c+3*r)%4)] : s_b[r+4*((c+r)%4)];
         end
      end
      for (int i = 0; i < 16; i++) begin
         sb_b[i] = decrypt ? INV_SBOX[sh_b[i]] : SBOX[sh_b[i]];
         ak_b[i] = sb_b[i] ^ round_key[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) begin
         fwd_b[i] = decrypt ? ak_b[i] : sb_b[i];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            mx_b[4*c+r] = 8'h00;
            for (int k = 0; k < 4; k++) begin
               x2 = xtime(fwd_b[4*c+((r+k)%4)]);
               x4 = xtime(x2);
               x8 = xtime(x4);
               case (k)
                  0: mx_b[4*c+r] = mx_b[4*c+r] ^ (decrypt ? (x8 ^ x4 ^ x2) : x2);
                  1: mx_b[4*c+r] = mx_b[4*c+r] ^ (decrypt ? (x8 ^ x2 ^ fwd_b[4*c+((r+k)%4)])
                                                          : (x2 ^ fwd_b[4*c+((r+k)%4)]));
                  2: mx_b[4*c+r] = mx_b[4*c+r] ^ (decrypt ? (x8 ^ x4 ^ fwd_b[4*c+((r+k)%4)])
                                                          : fwd_b[4*c+((r+k)%4)]);
                  default: mx_b[4*c+r] = mx_b[4*c+r] ^ (decrypt ? (x8 ^ fwd_b[4*c+((r+k)%4)])
                                                                : fwd_b[4*c+((r+k)%4)]);
               endcase
            end
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (last) begin
            result[127-8*i -: 8] = ak_b[i];
         end else if (decrypt) begin
            result[127-8*i -: 8] = mx_b[i];
         end else begin
            result[127-8*i -: 8] = mx_b[i] ^ round_key[127-8*i -: 8];
         end
      end
   end

endmodule

// ----- hw/rtl/aes128_block_cipher_top.sv -----
// Channel  | Ports                          | Moves
// ---------+--------------------------------+------------------------------
// request  | req_valid/req_ready/req_data   | one block item plus op
// response | rsp_valid/rsp_ready/rsp_data   | one result block item
// config   | csr_valid/csr_ready/csr_index  | key half write (index 0 high,
//          | csr_data                       | 1 low)
//
// After a key write (or reset), the first item runs a key expansion (one
// 64-bit round key half written to the 22-entry RAM per cycle). Each of the
// 11 round keys is then fetched in two halves through the single 64-bit read
// port (ST_FETCH0, ST_FETCH1) and applied in ST_ROUND, key 0 by a plain XOR
// and the rest on the shared round unit; ST_DONE then moves the block to the
// result register, and only back in idle is the next item taken.
// Reset clears control and the key; the RAM holds garbage until expanded.
// The result register holds until taken while the next item runs; a finished
// item waits in the done state while that register is still full.
// req_ready is low while busy and while a key write is offered.
module aes128_block_cipher_top #(
   parameter int NumRounds = aes128_pkg::NumRounds
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  aes128_pkg::req_payload_type   req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output aes128_pkg::rsp_payload_type   rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [0:0]                    csr_index,
   input  logic [63:0]                   csr_data
);

   import aes128_pkg::*;

   localparam int RamDepth  = 2 * (NumRounds + 1);
   localparam int AddrW     = $clog2(RamDepth);
   localparam int RoundW    = $clog2(NumRounds + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXPAND = 6'b000010,
      ST_FETCH0 = 6'b000100,
      ST_FETCH1 = 6'b001000,
      ST_ROUND  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [63:0]     key_high_ff, key_low_ff;
   logic            keys_ready_ff, keys_ready_in;
   logic [127:0]    win_ff, win_in;        // current round key during expansion
   logic [127:0]    win_next4;
   logic [AddrW-1:0] word_ff, word_in;     // RAM entry being written
   logic [7:0]      rcon_ff, rcon_in;
   logic [RoundW-1:0] round_ff, round_in;  // count of round keys applied
   logic            op_ff;
   logic [127:0]    blk_ff, blk_in;
   logic [63:0]     khi_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [127:0]    rsp_ff;
   logic            rsp_load;
   logic            ram_we;
   logic [AddrW-1:0] ram_waddr, ram_raddr;
   logic [63:0]     ram_wdata, ram_rdata;
   logic            fetch_half;
   logic [RoundW-1:0] key_idx;
   logic [127:0]    round_out;
   logic            accept;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = {rsp_ff[127:64], rsp_ff[63:0]};
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Round key index in application order
   assign key_idx = op_ff ? RoundW'(NumRounds - int'(round_ff)) : round_ff;

   // Expansion writes the high half on even entries and the low half on odd ones.
   always_comb begin
      fetch_half = (state_ff == ST_FETCH1);
      ram_raddr  = AddrW'({key_idx, fetch_half});
      ram_we     = (state_ff == ST_EXPAND);
      ram_waddr  = word_ff;
      ram_wdata  = word_ff[0] ? win_ff[63:0] : win_ff[127:64];
   end

   aes128_ram #(.Width(64), .Depth(RamDepth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   aes128_round u_round (
      .decrypt   (op_ff),
      .last      (round_ff == RoundW'(NumRounds)),
      .state     (blk_ff),
      .round_key ({khi_ff, ram_rdata}),
      .result    (round_out)
   );

   // Next round key from the current one
   always_comb begin
      logic [31:0] w0, w1, w2, w3;
      w0 = win_ff[127:96] ^ sub_word({win_ff[23:0], win_ff[31:24]}) ^ {rcon_ff, 24'd0};
      w1 = win_ff[95:64] ^ w0;
      w2 = win_ff[63:32] ^ w1;
      w3 = win_ff[31:0]  ^ w2;
      win_next4 = {w0, w1, w2, w3};
   end

   always_comb begin
      state_in      = state_ff;
      keys_ready_in = keys_ready_ff;
      win_in        = win_ff;
      word_in       = word_ff;
      rcon_in       = rcon_ff;
      round_in      = round_ff;
      blk_in        = blk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               keys_ready_in = 1'b0;
            end
            if (accept) begin
               blk_in   = {req_data.block_high, req_data.block_low};
               round_in = '0;
               if (keys_ready_ff) begin
                  state_in = ST_FETCH0;
               end else begin
                  win_in   = {key_high_ff, key_low_ff};
                  word_in  = '0;
                  rcon_in  = 8'h01;
                  state_in = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            // advance the window once both halves of a round key are written
            if (word_ff[0]) begin
               win_in  = win_next4;
               rcon_in = xtime(rcon_ff);
            end
            if (word_ff == AddrW'(RamDepth - 1)) begin
               keys_ready_in = 1'b1;
               state_in      = ST_FETCH0;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         ST_FETCH0: state_in = ST_FETCH1;
         ST_FETCH1: state_in = ST_ROUND;
         ST_ROUND: begin
            if (round_ff == '0) begin
               blk_in = blk_ff ^ {khi_ff, ram_rdata};
            end else begin
               blk_in = round_out;
            end
            if (round_ff == RoundW'(NumRounds)) begin
               state_in = ST_DONE;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = ST_FETCH0;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_ready_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         key_high_ff   <= '0;
         key_low_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_HIGH: key_high_ff <= csr_data;
               CSR_KEY_LOW:  key_low_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      rcon_ff  <= rcon_in;
      round_ff <= round_in;
      blk_ff   <= blk_in;
      win_ff   <= win_in;
      if (state_ff == ST_IDLE && accept) begin
         op_ff <= req_data.op;
      end
      if (state_ff == ST_FETCH1) begin
         khi_ff <= ram_rdata;
      end
      if (rsp_load) begin
         rsp_ff <= blk_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("result dropped or changed while waiting");
   a_keys_before_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> keys_ready_ff)
      else $error("round ran without key schedule");
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("result not presented");
`endif

endmodule
